[src/vlrf_pkg.sv]
// ----------------------------------------------------------------------------
// vlrf_pkg
// Shared types and constants of the variable-length record ring FIFO.
// ----------------------------------------------------------------------------
package vlrf_pkg;

  localparam int LEN_W      = 12;   // record length field
  localparam int BYTES_W    = 13;   // held byte count
  localparam int COUNT_W    = 11;   // held record count
  localparam int STATUS_W   = 3;
  localparam int CFG_SIZE_W = 13;   // ring_size register
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int HDR_BYTES  = 4;
  localparam int STEP_W     = $clog2(HDR_BYTES);
  localparam int HDR_W      = 8 * HDR_BYTES;

  localparam logic [CFG_SIZE_W-1:0] RING_SIZE_RST = 13'd4096;
  localparam logic [CFG_SIZE_W-1:0] RING_SIZE_MIN = 13'd8;

  // register index, taken from the word address bit of paddr
  localparam logic REG_RING_SIZE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_NO_OPEN = 3'd3,
    STS_CORRUPT = 3'd4
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_HDR_WR,
    S_DATA_WR,
    S_HDR_RD,
    S_HDR_CHK,
    S_DATA_RD,
    S_DATA_OUT,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_item;  // latch the accepted item, clear the result
    logic    open_push;  // restart the pending tail at the write pointer
    logic    wr_hdr;     // write one header byte at the pending tail
    logic    wr_data;    // write the data byte at the pending tail
    logic    commit;     // make the pending record visible
    logic    hdr_rd;     // read one header byte of the oldest record
    logic    pop_open;   // consume the header, start reading the record
    logic    data_rd;    // read one data byte at the read pointer
    logic    data_take;  // hand the read byte to the result
    logic    clear;      // drop all records
    logic    set_status;
    status_t status;
    logic    out_load;   // move the result to the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_pop;
    logic start;
    logic fits;
    logic len_zero;
    logic push_rem_zero;
    logic push_last;
    logic pop_rem_zero;
    logic count_zero;
    logic used_lt4;
    logic step_last;
    logic hdr_bad;
    logic hdr_len_zero;
  } dp_stat_t;

endpackage

[src/vlrf_ctrl.sv]
// ----------------------------------------------------------------------------
// vlrf_ctrl
// Sequencer: steps the datapath through one item and owns both handshakes.
// ----------------------------------------------------------------------------
module vlrf_ctrl
  import vlrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!st.op_pop) begin
          if (st.start) state_nxt = st.fits ? S_HDR_WR : S_FINISH;
          else          state_nxt = st.push_rem_zero ? S_FINISH : S_DATA_WR;
        end else if (!st.pop_rem_zero) begin
          state_nxt = S_DATA_RD;
        end else if (st.count_zero || st.used_lt4) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_HDR_RD;
        end
      end
      S_HDR_WR: begin
        if (st.step_last) state_nxt = st.len_zero ? S_FINISH : S_DATA_WR;
      end
      S_DATA_WR: state_nxt = S_FINISH;
      S_HDR_RD: begin
        if (st.step_last) state_nxt = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        state_nxt = (st.hdr_bad || st.hdr_len_zero) ? S_FINISH : S_DATA_RD;
      end
      S_DATA_RD:  state_nxt = S_DATA_OUT;
      S_DATA_OUT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = STS_OK;
    unique case (state_r)
      S_IDLE: cmd.load_item = in_valid;
      S_DECIDE: begin
        if (!st.op_pop) begin
          if (st.start) begin
            cmd.open_push = 1'b1;
            if (!st.fits) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_FULL;
            end
          end else if (st.push_rem_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = STS_NO_OPEN;
          end
        end else if (st.pop_rem_zero) begin
          if (st.count_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = STS_EMPTY;
          end else if (st.used_lt4) begin
            cmd.clear      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = STS_CORRUPT;
          end
        end
      end
      S_HDR_WR: begin
        cmd.wr_hdr = 1'b1;
        cmd.commit = st.step_last && st.len_zero;
      end
      S_DATA_WR: begin
        cmd.wr_data = 1'b1;
        cmd.commit  = st.push_last;
      end
      S_HDR_RD: cmd.hdr_rd = 1'b1;
      S_HDR_CHK: begin
        if (st.hdr_bad) begin
          cmd.clear      = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = STS_CORRUPT;
        end else begin
          cmd.pop_open = 1'b1;
        end
      end
      S_DATA_RD:  cmd.data_rd   = 1'b1;
      S_DATA_OUT: cmd.data_take = 1'b1;
      S_FINISH:   cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/vlrf_dpath.sv]
// ----------------------------------------------------------------------------
// vlrf_dpath
// Byte ring memory, pointers, counters, header handling and result registers.
// ----------------------------------------------------------------------------
module vlrf_dpath
  import vlrf_pkg::*;
#(
  parameter int RING_BYTES = 4096
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              st,
  input  logic                  cfg_we,
  input  logic [CFG_SIZE_W-1:0] cfg_wdata,
  output logic [CFG_SIZE_W-1:0] cfg_ring_size,
  input  logic                  in_operation,
  input  logic                  in_start_record,
  input  logic [LEN_W-1:0]      in_record_length,
  input  logic [7:0]            in_data_byte,
  output logic [STATUS_W-1:0]   out_status,
  output logic [7:0]            out_popped_byte,
  output logic [LEN_W-1:0]      out_popped_length,
  output logic                  out_first_of_record,
  output logic                  out_last_of_record,
  output logic [COUNT_W-1:0]    out_records_held,
  output logic [BYTES_W-1:0]    out_bytes_held
);

  localparam int PW  = $clog2(RING_BYTES);
  localparam int SZW = PW + 1;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SZW-1:0] sz);
    logic [SZW-1:0] n;
    n = {1'b0, p} + SZW'(1);
    return (n >= sz) ? '0 : n[PW-1:0];
  endfunction

  function automatic logic [SZW-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v);
    logic [SZW-1:0] r;
    if (v < RING_SIZE_MIN)                r = SZW'(RING_SIZE_MIN);
    else if (32'(v) > 32'(RING_BYTES))    r = SZW'(RING_BYTES);
    else                                  r = SZW'(v);
    return r;
  endfunction

  // control state
  logic [CFG_SIZE_W-1:0] ring_size_r, ring_size_nxt;
  logic [SZW-1:0]        size_r, size_nxt;
  logic [PW-1:0]         wp_r, wp_nxt;
  logic [PW-1:0]         pend_r, pend_nxt;
  logic [PW-1:0]         rp_r, rp_nxt;
  logic [PW-1:0]         hp_r, hp_nxt;
  logic [BYTES_W-1:0]    bytes_r, bytes_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [LEN_W-1:0]      push_rem_r, push_rem_nxt;
  logic [LEN_W-1:0]      push_len_r, push_len_nxt;
  logic [LEN_W-1:0]      pop_rem_r, pop_rem_nxt;
  logic [LEN_W-1:0]      pop_len_r, pop_len_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  cap_r;

  // item and result payload
  op_t                   item_op_r;
  logic                  item_start_r;
  logic [LEN_W-1:0]      item_len_r;
  logic [7:0]            item_db_r;
  status_t               res_status_r;
  logic [7:0]            res_byte_r;
  logic [LEN_W-1:0]      res_len_r;
  logic                  res_first_r;
  logic                  res_last_r;

  logic [7:0]            mem [RING_BYTES];
  logic [7:0]            rdata_r;
  logic [7:0]            wdata;
  logic                  mem_we, mem_re;
  logic [PW-1:0]         raddr;
  logic [HDR_W-1:0]      hdr_r;
  logic [HDR_W-1:0]      hdr_full;
  logic [LEN_W-1:0]      hdr_len;
  logic [LEN_W-1:0]      push_base;
  logic [PW-1:0]         pend_adv, rp_adv, hp_adv;

  assign pend_adv  = adv(pend_r, size_r);
  assign rp_adv    = adv(rp_r, size_r);
  assign hp_adv    = adv(hp_r, size_r);
  assign push_base = item_start_r ? item_len_r : push_rem_r;

  // last header byte is still in the read register while the check runs
  assign hdr_full = {rdata_r, hdr_r[HDR_W-1:8]};
  assign hdr_len  = hdr_full[LEN_W-1:0];

  assign st.op_pop        = (item_op_r == OP_POP);
  assign st.start         = item_start_r;
  assign st.fits          = (32'(bytes_r) + 32'(item_len_r) + 32'(HDR_BYTES)) <= 32'(size_r);
  assign st.len_zero      = (push_len_r == '0);
  assign st.push_rem_zero = (push_rem_r == '0);
  assign st.push_last     = (push_base == LEN_W'(1));
  assign st.pop_rem_zero  = (pop_rem_r == '0);
  assign st.count_zero    = (count_r == '0);
  assign st.used_lt4      = (bytes_r < BYTES_W'(HDR_BYTES));
  assign st.step_last     = (step_r == STEP_W'(HDR_BYTES - 1));
  assign st.hdr_bad       = (hdr_full[HDR_W-1:LEN_W] != '0)
                          || (32'(bytes_r) < 32'(hdr_len) + 32'(HDR_BYTES));
  assign st.hdr_len_zero  = (hdr_len == '0);

  assign cfg_ring_size = ring_size_r;

  always_comb begin
    ring_size_nxt = ring_size_r;
    size_nxt      = size_r;
    wp_nxt        = wp_r;
    pend_nxt      = pend_r;
    rp_nxt        = rp_r;
    hp_nxt        = hp_r;
    bytes_nxt     = bytes_r;
    count_nxt     = count_r;
    push_rem_nxt  = push_rem_r;
    push_len_nxt  = push_len_r;
    pop_rem_nxt   = pop_rem_r;
    pop_len_nxt   = pop_len_r;
    step_nxt      = step_r;

    if (cmd.load_item) begin
      step_nxt = '0;
      hp_nxt   = rp_r;
    end
    if (cmd.open_push) begin
      pend_nxt     = wp_r;
      push_rem_nxt = '0;
      push_len_nxt = item_len_r;
    end
    if (cmd.wr_hdr || cmd.hdr_rd) step_nxt = step_r + STEP_W'(1);
    if (cmd.wr_hdr || cmd.wr_data) pend_nxt = pend_adv;
    if (cmd.wr_data) push_rem_nxt = push_base - LEN_W'(1);
    if (cmd.commit) begin
      // commit always rides on the record's final write
      wp_nxt    = pend_adv;
      bytes_nxt = bytes_r + BYTES_W'(push_len_r) + BYTES_W'(HDR_BYTES);
      count_nxt = count_r + COUNT_W'(1);
    end
    if (cmd.hdr_rd) hp_nxt = hp_adv;
    if (cmd.pop_open) begin
      rp_nxt      = hp_r;
      bytes_nxt   = bytes_r - BYTES_W'(HDR_BYTES);
      count_nxt   = count_r - COUNT_W'(1);
      pop_len_nxt = hdr_len;
      pop_rem_nxt = hdr_len;
    end
    if (cmd.data_rd) rp_nxt = rp_adv;
    if (cmd.data_take) begin
      if (bytes_r != '0) bytes_nxt = bytes_r - BYTES_W'(1);
      pop_rem_nxt = pop_rem_r - LEN_W'(1);
    end
    if (cfg_we) begin
      ring_size_nxt = cfg_wdata;
      size_nxt      = clamp_size(cfg_wdata);
    end
    if (cmd.clear || cfg_we) begin
      wp_nxt       = '0;
      pend_nxt     = '0;
      rp_nxt       = '0;
      bytes_nxt    = '0;
      count_nxt    = '0;
      push_rem_nxt = '0;
      pop_rem_nxt  = '0;
      pop_len_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      size_r      <= clamp_size(RING_SIZE_RST);
      wp_r        <= '0;
      pend_r      <= '0;
      rp_r        <= '0;
      hp_r        <= '0;
      bytes_r     <= '0;
      count_r     <= '0;
      push_rem_r  <= '0;
      push_len_r  <= '0;
      pop_rem_r   <= '0;
      pop_len_r   <= '0;
      step_r      <= '0;
      cap_r       <= 1'b0;
    end else begin
      ring_size_r <= ring_size_nxt;
      size_r      <= size_nxt;
      wp_r        <= wp_nxt;
      pend_r      <= pend_nxt;
      rp_r        <= rp_nxt;
      hp_r        <= hp_nxt;
      bytes_r     <= bytes_nxt;
      count_r     <= count_nxt;
      push_rem_r  <= push_rem_nxt;
      push_len_r  <= push_len_nxt;
      pop_rem_r   <= pop_rem_nxt;
      pop_len_r   <= pop_len_nxt;
      step_r      <= step_nxt;
      cap_r       <= cmd.hdr_rd;
    end
  end

  // header bytes: length low, length high, then two zero bytes
  always_comb begin
    wdata = item_db_r;
    if (cmd.wr_hdr) begin
      case (step_r)
        2'd0:    wdata = push_len_r[7:0];
        2'd1:    wdata = 8'(push_len_r[LEN_W-1:8]);
        default: wdata = '0;
      endcase
    end
  end

  assign mem_we = cmd.wr_hdr || cmd.wr_data;
  assign mem_re = cmd.hdr_rd || cmd.data_rd;
  assign raddr  = cmd.hdr_rd ? hp_r : rp_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[pend_r] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cap_r) hdr_r <= {rdata_r, hdr_r[HDR_W-1:8]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op_r    <= op_t'(in_operation);
      item_start_r <= in_start_record;
      item_len_r   <= in_record_length;
      item_db_r    <= in_data_byte;
      res_status_r <= STS_OK;
      res_byte_r   <= '0;
      res_len_r    <= '0;
      res_first_r  <= 1'b0;
      res_last_r   <= 1'b0;
    end
    if (cmd.set_status) res_status_r <= cmd.status;
    if (cmd.pop_open) begin
      res_first_r <= 1'b1;
      res_len_r   <= hdr_len;
      res_last_r  <= (hdr_len == '0);
    end
    if (cmd.data_take) begin
      res_byte_r <= rdata_r;
      res_len_r  <= pop_len_r;
      res_last_r <= (pop_rem_r == LEN_W'(1));
    end
    if (cmd.out_load) begin
      out_status          <= res_status_r;
      out_popped_byte     <= res_byte_r;
      out_popped_length   <= res_len_r;
      out_first_of_record <= res_first_r;
      out_last_of_record  <= res_last_r;
      out_records_held    <= count_r;
      out_bytes_held      <= bytes_r;
    end
  end

endmodule

[src/variable_length_record_ring_fifo.sv]
// ----------------------------------------------------------------------------
// variable_length_record_ring_fifo
// Byte ring of length-prefixed records with push/pop item interface.
// ----------------------------------------------------------------------------
// One item is handled at a time, each through a single-port byte RAM that does
// one read or one write per cycle. A push of the next byte of an open record
// writes that byte; a push that opens a record writes the four header bytes,
// then the first data byte (header only if zero-length, nothing if rejected);
// a pop inside a record reads one data byte; a pop that opens a record reads
// the four header bytes, checks them and reads the first data byte (none for a
// zero-length record). Answers without RAM access (empty, no open record,
// corrupt found before the header) need none. The next item is accepted while
// the previous result still waits in the output register; a result that
// cannot yet enter the output register holds the item in its last cycle.
// Writing ring_size (byte address 0) empties the ring at once; no clearing
// pass is needed after reset, since only committed bytes are ever read.
module variable_length_record_ring_fifo
  import vlrf_pkg::*;
#(
  parameter int RING_BYTES = 4096
)(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic                in_start_record,
  input  logic [LEN_W-1:0]    in_record_length,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [7:0]          out_popped_byte,
  output logic [LEN_W-1:0]    out_popped_length,
  output logic                out_first_of_record,
  output logic                out_last_of_record,
  output logic [COUNT_W-1:0]  out_records_held,
  output logic [BYTES_W-1:0]  out_bytes_held
);

  dp_cmd_t               cmd;
  dp_stat_t              st;
  logic                  reg_sel;
  logic                  cfg_we;
  logic [CFG_SIZE_W-1:0] ring_size;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_RING_SIZE);
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = (psel && reg_sel) ? APB_DW'(ring_size) : '0;

  vlrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  vlrf_dpath #(
    .RING_BYTES (RING_BYTES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_we              (cfg_we),
    .cfg_wdata           (pwdata[CFG_SIZE_W-1:0]),
    .cfg_ring_size       (ring_size),
    .in_operation        (in_operation),
    .in_start_record     (in_start_record),
    .in_record_length    (in_record_length),
    .in_data_byte        (in_data_byte),
    .out_status          (out_status),
    .out_popped_byte     (out_popped_byte),
    .out_popped_length   (out_popped_length),
    .out_first_of_record (out_first_of_record),
    .out_last_of_record  (out_last_of_record),
    .out_records_held    (out_records_held),
    .out_bytes_held      (out_bytes_held)
  );

endmodule

[src/vlrf_checker.sv]
// ----------------------------------------------------------------------------
// vlrf_checker
// Port-level checks of the record ring FIFO result stream.
// ----------------------------------------------------------------------------
module vlrf_checker
  import vlrf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [7:0]          out_popped_byte,
  input logic [LEN_W-1:0]    out_popped_length,
  input logic                out_first_of_record,
  input logic                out_last_of_record,
  input logic [COUNT_W-1:0]  out_records_held,
  input logic [BYTES_W-1:0]  out_bytes_held
);

  // a stalled transfer keeps its result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_byte) && $stable(out_bytes_held)
      && $stable(out_records_held))
    else $error("result changed while stalled");

  a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |-> out_records_held == '0)
    else $error("empty answer with records held");

  a_corrupt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_CORRUPT |-> out_records_held == '0 && out_bytes_held == '0)
    else $error("corrupt answer left data in the ring");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_popped_byte == '0 && out_popped_length == '0
      && !out_first_of_record && !out_last_of_record)
    else $error("error answer carries pop fields");

  a_zero_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_of_record && out_popped_length == '0 |-> out_last_of_record)
    else $error("zero-length record not marked last");

endmodule

bind variable_length_record_ring_fifo vlrf_checker u_vlrf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_popped_byte     (out_popped_byte),
  .out_popped_length   (out_popped_length),
  .out_first_of_record (out_first_of_record),
  .out_last_of_record  (out_last_of_record),
  .out_records_held    (out_records_held),
  .out_bytes_held      (out_bytes_held)
);

[dv/variable_length_record_ring_fifo_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_length_record_ring_fifo_tb
// Drives push and pop byte transfers into the record ring FIFO with random
// gaps and output stalls, and runs the traffic across several ring sizes set
// over APB. A behavioral copy of the ring predicts each result, and every
// result field is checked in order against that prediction.
// ----------------------------------------------------------------------------
module variable_length_record_ring_fifo_tb;
  import vlrf_pkg::*;

  localparam int RING_BYTES = 4096;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [APB_AW-1:0] RING_SIZE_ADDR = {REG_RING_SIZE, 2'b00};

  typedef struct {
    status_t            status;
    logic [7:0]         data;
    logic [LEN_W-1:0]   length;
    logic               first;
    logic               last;
    logic [COUNT_W-1:0] records;
    logic [BYTES_W-1:0] held;
  } fifo_answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = 1'b0;
  logic                in_start_record = 1'b0;
  logic [LEN_W-1:0]    in_record_length = '0;
  logic [7:0]          in_data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [7:0]          out_popped_byte;
  logic [LEN_W-1:0]    out_popped_length;
  logic                out_first_of_record;
  logic                out_last_of_record;
  logic [COUNT_W-1:0]  out_records_held;
  logic [BYTES_W-1:0]  out_bytes_held;

  fifo_answer_t answers_due[$];
  int unsigned  mismatches = 0;
  int unsigned  gap_max = 10;
  int unsigned  ready_max = 10;
  int unsigned  ready_wait = 0;
  int unsigned  quiet_cycles = 0;

  // ring copy used for prediction
  logic [7:0]            ring_copy [RING_BYTES];
  logic [CFG_SIZE_W-1:0] size_reg;
  int unsigned           wr_ptr, tail_ptr, rd_ptr;
  int unsigned           held_bytes, held_records;
  int unsigned           push_left, pop_left, pop_len;

  variable_length_record_ring_fifo dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned ring_span();
    int unsigned s = size_reg;
    if (s < 8) s = 8;
    if (s > RING_BYTES) s = RING_BYTES;
    return s;
  endfunction

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1 >= ring_span()) ? 0 : p + 1;
  endfunction

  function automatic void write_tail(logic [7:0] v);
    ring_copy[tail_ptr] = v;
    tail_ptr = wrap_next(tail_ptr);
  endfunction

  function automatic logic [7:0] read_at(inout int unsigned p);
    logic [7:0] v;
    v = ring_copy[p];
    p = wrap_next(p);
    return v;
  endfunction

  function automatic void empty_ring();
    wr_ptr = 0;
    tail_ptr = 0;
    rd_ptr = 0;
    held_bytes = 0;
    held_records = 0;
    push_left = 0;
    pop_left = 0;
    pop_len = 0;
  endfunction

  function automatic void commit_record(int unsigned n);
    wr_ptr = tail_ptr;
    held_bytes += 4 + n;
    held_records += 1;
  endfunction

  function automatic fifo_answer_t predict_answer(op_t op, logic start,
                                                  logic [LEN_W-1:0] len, logic [7:0] db);
    fifo_answer_t a;
    int unsigned  free_bytes, p, hdr_len;
    a.status = STS_OK;
    a.data = '0;
    a.length = '0;
    a.first = 1'b0;
    a.last = 1'b0;
    if (op == OP_PUSH) begin
      if (start) begin
        free_bytes = (held_bytes < ring_span()) ? ring_span() - held_bytes : 0;
        // drop whatever the open record had written so far
        push_left = 0;
        tail_ptr = wr_ptr;
        if (free_bytes < 4 + len) begin
          a.status = STS_FULL;
        end else begin
          write_tail(len[7:0]);
          write_tail({4'b0, len[11:8]});
          write_tail(8'h00);
          write_tail(8'h00);
          if (len == 0) begin
            commit_record(0);
          end else begin
            write_tail(db);
            push_left = len - 1;
            if (push_left == 0) commit_record(len);
          end
        end
      end else if (push_left == 0) begin
        a.status = STS_NO_OPEN;
      end else begin
        write_tail(db);
        push_left -= 1;
        if (push_left == 0) begin
          // length comes back from the record's own header
          p = wr_ptr;
          hdr_len = 32'(read_at(p));
          hdr_len |= 32'(read_at(p)) << 8;
          commit_record(hdr_len);
        end
      end
    end else begin
      if (pop_left == 0) begin
        if (held_records == 0) begin
          a.status = STS_EMPTY;
        end else if (held_bytes < 4) begin
          empty_ring();
          a.status = STS_CORRUPT;
        end else begin
          p = rd_ptr;
          hdr_len = 32'(read_at(p));
          hdr_len |= 32'(read_at(p)) << 8;
          hdr_len |= 32'(read_at(p)) << 16;
          hdr_len |= 32'(read_at(p)) << 24;
          if (hdr_len > 32'hFFF || held_bytes < 4 + hdr_len) begin
            empty_ring();
            a.status = STS_CORRUPT;
          end else begin
            rd_ptr = p;
            held_bytes -= 4;
            held_records -= 1;
            pop_len = hdr_len;
            a.length = hdr_len[LEN_W-1:0];
            a.first = 1'b1;
            if (hdr_len == 0) begin
              a.last = 1'b1;
            end else begin
              a.data = read_at(rd_ptr);
              held_bytes -= 1;
              pop_left = hdr_len - 1;
              a.last = (pop_left == 0);
            end
          end
        end
      end else begin
        a.data = read_at(rd_ptr);
        if (held_bytes > 0) held_bytes -= 1;
        pop_left -= 1;
        a.length = pop_len[LEN_W-1:0];
        a.last = (pop_left == 0);
      end
    end
    a.records = held_records[COUNT_W-1:0];
    a.held = held_bytes[BYTES_W-1:0];
    return a;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // output stall: hold ready low for a random count after each transfer
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      ready_wait = $urandom_range(0, ready_max);
      out_ready <= (ready_wait == 0);
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_ready <= (ready_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fifo_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected none actual status %0d",
                 $time, out_status);
      end else begin
        want = answers_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("popped_byte", 32'(want.data), 32'(out_popped_byte));
        check_field("popped_length", 32'(want.length), 32'(out_popped_length));
        check_field("first_of_record", 32'(want.first), 32'(out_first_of_record));
        check_field("last_of_record", 32'(want.last), 32'(out_last_of_record));
        check_field("records_held", 32'(want.records), 32'(out_records_held));
        check_field("bytes_held", 32'(want.held), 32'(out_bytes_held));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("variable_length_record_ring_fifo_tb failed");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic start, logic [LEN_W-1:0] len, logic [7:0] db);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_start_record <= start;
    in_record_length <= len;
    in_data_byte <= db;
    do @(posedge clk); while (!in_ready);
    answers_due.push_back(predict_answer(op, start, len, db));
  endtask

  task automatic send_pop();
    send_item(OP_POP, 1'($urandom), LEN_W'($urandom), 8'($urandom));
  endtask

  task automatic send_open(logic [LEN_W-1:0] len, logic [7:0] db);
    send_item(OP_PUSH, 1'b1, len, db);
  endtask

  task automatic send_byte(logic [7:0] db);
    send_item(OP_PUSH, 1'b0, LEN_W'($urandom), db);
  endtask

  // wait out every pending result, then let the block settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_transfer(logic wr, logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= RING_SIZE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      size_reg = value[CFG_SIZE_W-1:0];
      empty_ring();
    end else begin
      check_field("ring_size", 32'(size_reg), prdata);
    end
  endtask

  // idle between the write and the read-back transfer
  task automatic set_ring_size(logic [APB_DW-1:0] value);
    cfg_transfer(1'b1, value);
    @(posedge clk);
    cfg_transfer(1'b0, '0);
  endtask

  function automatic int unsigned cap(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [LEN_W-1:0] record_len(int unsigned span);
    int unsigned pick, top;
    pick = $urandom_range(0, 99);
    top = span - 4;
    if (pick < 10) return '0;
    if (pick < 70) return LEN_W'($urandom_range(1, cap(6, top)));
    if (pick < 95) return LEN_W'($urandom_range(1, cap(24, top)));
    return LEN_W'($urandom_range(1, cap(200, top)));
  endfunction

  // mostly complete records with random content, plus reopen and stray noise
  task automatic run_traffic(int unsigned count);
    int unsigned sent, pick, span;
    span = ring_span();
    for (sent = 0; sent < count; sent++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        if (push_left > 0) send_byte(8'($urandom));
        else send_open(record_len(span), 8'($urandom));
      end else if (pick < 90) begin
        send_pop();
      end else if (pick < 94) begin
        send_open(record_len(span), 8'($urandom));
      end else if (pick < 97) begin
        send_byte(8'($urandom));
      end else begin
        send_open(LEN_W'($urandom_range(0, 4092)), 8'($urandom));
      end
    end
    finish_phase();
  endtask

  task automatic test_register_reset();
    cfg_transfer(1'b0, '0);
  endtask

  task automatic test_corner_items();
    send_pop();
    send_byte(8'h3C);
    send_open(12'd0, 8'hFF);
    send_open(12'd1, 8'hFF);
    send_open(12'd3, 8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    repeat (5) send_pop();
    send_pop();
    // reopen drops the partial record
    send_open(12'd5, 8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_open(12'd2, 8'h44);
    send_byte(8'h55);
    send_open(12'd4092, 8'h80);
    send_byte(8'h66);
    send_pop();
    send_pop();
    // largest record fits an empty full-size ring
    send_open(12'd4092, 8'h01);
    send_byte(8'hFE);
    finish_phase();
  endtask

  task automatic test_minimum_ring();
    set_ring_size(32'd8);
    run_traffic(100);
    set_ring_size(32'd0);
    run_traffic(50);
  endtask

  task automatic test_wrapping_rings();
    set_ring_size(32'd13);
    run_traffic(80);
    set_ring_size(32'd64);
    run_traffic(80);
    set_ring_size(32'($urandom_range(9, 400)));
    run_traffic(80);
  endtask

  task automatic test_maximum_ring();
    set_ring_size(32'hFFFF_FFFF);
    run_traffic(60);
    set_ring_size(32'd4096);
    run_traffic(150);
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    ready_max = 0;
    set_ring_size(32'd37);
    run_traffic(80);
    ready_max = 10;
    set_ring_size(32'd256);
    run_traffic(60);
    gap_max = 10;
  endtask

  initial begin
    size_reg = RING_SIZE_RST;
    foreach (ring_copy[i]) ring_copy[i] = 8'h00;
    empty_ring();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_corner_items();
    test_minimum_ring();
    test_wrapping_rings();
    test_maximum_ring();
    test_back_to_back();
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("variable_length_record_ring_fifo_tb passed");
    end else begin
      $display("variable_length_record_ring_fifo_tb failed");
    end
    $finish;
  end

endmodule
